/* hdl/wsfe_pkg.sv */
// Package: constants, length-form type and header byte functions for the WebSocket frame encoder.
package wsfe_pkg;

   localparam logic [7:0]  FIN_BIT     = 8'h80;
   localparam logic [7:0]  MASK_BIT    = 8'h80;
   localparam logic [7:0]  LEN16_CODE  = 8'h7E;
   localparam logic [7:0]  LEN64_CODE  = 8'h7F;
   localparam logic [31:0] LEN7_LIMIT  = 32'h0000_007D;
   localparam logic [31:0] LEN16_LIMIT = 32'h0000_FFFF;

   localparam logic REQ_START   = 1'b0;
   localparam logic REQ_PAYLOAD = 1'b1;

   typedef enum logic [1:0] {
      FORM_LEN7  = 2'd0,
      FORM_LEN16 = 2'd1,
      FORM_LEN64 = 2'd2
   } form_type;

   function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] k);
      logic [7:0] b;
      case (k)
         2'd0:    b = key[7:0];
         2'd1:    b = key[15:8];
         2'd2:    b = key[23:16];
         default: b = key[31:24];
      endcase
      return b;
   endfunction

   function automatic logic [3:0] hdr_last_idx(input form_type form);
      logic [3:0] n;
      case (form)
         FORM_LEN7:  n = 4'd5;
         FORM_LEN16: n = 4'd7;
         default:    n = 4'd13;
      endcase
      return n;
   endfunction

   // header byte at index 1..13; byte 0 is built at the start word
   function automatic logic [7:0] hdr_byte(input form_type form, input logic [3:0] idx,
                                           input logic [31:0] len, input logic [31:0] key);
      logic [7:0] b;
      b = 8'h00;
      case (form)
         FORM_LEN7: begin
            if (idx == 4'd1) b = MASK_BIT | {1'b0, len[6:0]};
            else             b = key_byte(key, idx[1:0] - 2'd2);
         end
         FORM_LEN16: begin
            case (idx)
               4'd1:    b = MASK_BIT | LEN16_CODE;
               4'd2:    b = len[15:8];
               4'd3:    b = len[7:0];
               default: b = key_byte(key, idx[1:0]);
            endcase
         end
         default: begin
            case (idx)
               4'd1:    b = MASK_BIT | LEN64_CODE;
               4'd6:    b = len[31:24];
               4'd7:    b = len[23:16];
               4'd8:    b = len[15:8];
               4'd9:    b = len[7:0];
               4'd10, 4'd11, 4'd12, 4'd13: b = key_byte(key, idx[1:0] - 2'd2);
               default: b = 8'h00;
            endcase
         end
      endcase
      return b;
   endfunction

endpackage

/* hdl/websocket_frame_encoder_top.sv */
// Top level: masked client WebSocket frame encoder, one wire byte per output word.
//
//   channel | direction | words
//   req_    | in        | start (opcode, length, key) or one payload byte
//   rsp_    | out       | one wire byte with header/last/error flags
//
// A payload word gives one output word; words can follow back to back while req_stall is low.
// A start word gives 6, 8 or 14 header words from the header sequencer, one per unstalled cycle;
// req_stall stays high until the last of them is loaded into the output register.
// Reset is synchronous and clears the frame state and the output valid.
// rsp_stall holds the output register; req_stall follows it while the register is full.
module websocket_frame_encoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [3:0]  req_opcode,
   input  logic [31:0] req_payload_length,
   input  logic [31:0] req_mask_key,
   input  logic [7:0]  req_payload_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_is_header,
   output logic        rsp_frame_last,
   output logic        rsp_seq_error
);
   import wsfe_pkg::*;

   logic [31:0] key_ff, key_in;
   logic [31:0] bytes_left_ff, bytes_left_in;
   logic [1:0]  key_phase_ff, key_phase_in;
   logic        frame_open_ff, frame_open_in;

   logic        hdr_active_ff, hdr_active_in;
   logic [3:0]  hdr_idx_ff, hdr_idx_in;
   form_type    hdr_form_ff, hdr_form_in;
   logic        hdr_empty_ff, hdr_empty_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        is_header_ff, is_header_in;
   logic        frame_last_ff, frame_last_in;
   logic        seq_error_ff, seq_error_in;

   logic        out_load, req_acc, hdr_end;
   logic [31:0] left_dec;

   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = hdr_active_ff || !out_load;
   assign req_acc   = req_valid && !req_stall;
   assign hdr_end   = (hdr_idx_ff == hdr_last_idx(hdr_form_ff));
   assign left_dec  = bytes_left_ff - 32'd1;

   always_comb begin
      key_in        = key_ff;
      bytes_left_in = bytes_left_ff;
      key_phase_in  = key_phase_ff;
      frame_open_in = frame_open_ff;
      hdr_active_in = hdr_active_ff;
      hdr_idx_in    = hdr_idx_ff;
      hdr_form_in   = hdr_form_ff;
      hdr_empty_in  = hdr_empty_ff;
      rsp_valid_in  = rsp_valid_ff;
      out_byte_in   = out_byte_ff;
      is_header_in  = is_header_ff;
      frame_last_in = frame_last_ff;
      seq_error_in  = seq_error_ff;
      if (hdr_active_ff && out_load) begin
         rsp_valid_in  = 1'b1;
         out_byte_in   = hdr_byte(hdr_form_ff, hdr_idx_ff, bytes_left_ff, key_ff);
         is_header_in  = 1'b1;
         frame_last_in = hdr_end && hdr_empty_ff;
         seq_error_in  = 1'b0;
         hdr_idx_in    = hdr_idx_ff + 4'd1;
         if (hdr_end) hdr_active_in = 1'b0;
      end else if (req_acc) begin
         rsp_valid_in = 1'b1;
         if (req_type == REQ_START) begin
            out_byte_in   = FIN_BIT | {4'h0, req_opcode};
            is_header_in  = 1'b1;
            frame_last_in = 1'b0;
            seq_error_in  = 1'b0;
            hdr_active_in = 1'b1;
            hdr_idx_in    = 4'd1;
            if (req_payload_length <= LEN7_LIMIT)       hdr_form_in = FORM_LEN7;
            else if (req_payload_length <= LEN16_LIMIT) hdr_form_in = FORM_LEN16;
            else                                        hdr_form_in = FORM_LEN64;
            hdr_empty_in  = (req_payload_length == 32'd0);
            key_in        = req_mask_key;
            bytes_left_in = req_payload_length;
            key_phase_in  = 2'd0;
            frame_open_in = (req_payload_length != 32'd0);
         end else if (!frame_open_ff) begin
            out_byte_in   = 8'h00;
            is_header_in  = 1'b0;
            frame_last_in = 1'b0;
            seq_error_in  = 1'b1;
         end else begin
            out_byte_in   = req_payload_byte ^ key_byte(key_ff, key_phase_ff);
            is_header_in  = 1'b0;
            frame_last_in = (left_dec == 32'd0);
            seq_error_in  = 1'b0;
            key_phase_in  = key_phase_ff + 2'd1;
            bytes_left_in = left_dec;
            if (left_dec == 32'd0) frame_open_in = 1'b0;
         end
      end else if (out_load) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff        <= '0;
         bytes_left_ff <= '0;
         key_phase_ff  <= '0;
         frame_open_ff <= 1'b0;
         hdr_active_ff <= 1'b0;
         hdr_idx_ff    <= '0;
         hdr_form_ff   <= FORM_LEN7;
         hdr_empty_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         key_ff        <= key_in;
         bytes_left_ff <= bytes_left_in;
         key_phase_ff  <= key_phase_in;
         frame_open_ff <= frame_open_in;
         hdr_active_ff <= hdr_active_in;
         hdr_idx_ff    <= hdr_idx_in;
         hdr_form_ff   <= hdr_form_in;
         hdr_empty_ff  <= hdr_empty_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      out_byte_ff   <= out_byte_in;
      is_header_ff  <= is_header_in;
      frame_last_ff <= frame_last_in;
      seq_error_ff  <= seq_error_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_is_header  = is_header_ff;
   assign rsp_frame_last = frame_last_ff;
   assign rsp_seq_error  = seq_error_ff;

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_seq_error |-> rsp_out_byte == 8'h00 && !rsp_is_header && !rsp_frame_last)
      else $error("error word carries data");

   a_empty_closed: assert property (@(posedge clock) disable iff (reset)
      hdr_active_ff && hdr_empty_ff |-> !frame_open_ff)
      else $error("empty frame left open");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      hdr_active_ff |-> hdr_idx_ff != 4'd0 && hdr_idx_ff <= hdr_last_idx(hdr_form_ff))
      else $error("header index out of range");

   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_last && !rsp_is_header && !hdr_active_ff |-> !frame_open_ff
         || $past(req_valid && !req_stall))
      else $error("frame open after last byte");

endmodule

/* verif/tb_top.sv */
// Testbench for the WebSocket frame encoder: directed and random frames checked against a predictor.
`timescale 1ns / 100ps

module tb_top;
   import wsfe_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int WORD_BUDGET = 350;
   localparam int DRAIN_CYCLES = 20;

   typedef struct {
      logic [7:0] data;
      logic       hdr;
      logic       last;
      logic       err;
   } wire_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_type = REQ_START;
   logic [3:0]  req_opcode = 4'h0;
   logic [31:0] req_payload_length = 32'h0;
   logic [31:0] req_mask_key = 32'h0;
   logic [7:0]  req_payload_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_is_header;
   logic        rsp_frame_last;
   logic        rsp_seq_error;

   wire_word_type wire_bytes_due[$];

   // predictor state for the open frame
   logic [31:0] frame_key = 32'h0;
   logic [31:0] frame_left = 32'h0;
   logic [1:0]  frame_phase = 2'd0;
   logic        frame_active = 1'b0;

   int words_sent = 0;
   int frames_started = 0;
   int payload_words = 0;
   int orphan_words = 0;
   int bytes_checked = 0;
   int mismatches = 0;
   int cycle_count = 0;

   logic quiet = 1'b0;
   int   pressure_req = 0;
   int   pressure_seen = 0;
   int   pressure_len = 0;
   int   hold_left = 0;

   websocket_frame_encoder_top u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_opcode         (req_opcode),
      .req_payload_length (req_payload_length),
      .req_mask_key       (req_mask_key),
      .req_payload_byte   (req_payload_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_is_header      (rsp_is_header),
      .rsp_frame_last     (rsp_frame_last),
      .rsp_seq_error      (rsp_seq_error)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic void due(input logic [7:0] b, input logic h, input logic l,
                               input logic e);
      wire_word_type w;
      w.data = b;
      w.hdr  = h;
      w.last = l;
      w.err  = e;
      wire_bytes_due.push_back(w);
   endfunction

   function automatic void encode_word(input logic kind, input logic [3:0] op,
                                       input logic [31:0] len, input logic [31:0] key,
                                       input logic [7:0] pbyte);
      logic [7:0] kb;
      logic       done;
      if (kind == REQ_START) begin
         due(FIN_BIT | {4'h0, op}, 1'b1, 1'b0, 1'b0);
         if (len <= LEN7_LIMIT) begin
            due(MASK_BIT | len[7:0], 1'b1, 1'b0, 1'b0);
         end else if (len <= LEN16_LIMIT) begin
            due(MASK_BIT | LEN16_CODE, 1'b1, 1'b0, 1'b0);
            due(len[15:8], 1'b1, 1'b0, 1'b0);
            due(len[7:0], 1'b1, 1'b0, 1'b0);
         end else begin
            due(MASK_BIT | LEN64_CODE, 1'b1, 1'b0, 1'b0);
            for (int i = 0; i < 4; i++) due(8'h00, 1'b1, 1'b0, 1'b0);
            for (int i = 3; i >= 0; i--) due(len[8*i +: 8], 1'b1, 1'b0, 1'b0);
         end
         for (int i = 0; i < 4; i++)
            due(key[8*i +: 8], 1'b1, (len == 32'h0) && (i == 3), 1'b0);
         frame_key    = key;
         frame_left   = len;
         frame_phase  = 2'd0;
         frame_active = (len != 32'h0);
         frames_started++;
      end else if (!frame_active) begin
         due(8'h00, 1'b0, 1'b0, 1'b1);
         orphan_words++;
      end else begin
         kb = frame_key[8*frame_phase +: 8];
         frame_phase = frame_phase + 2'd1;
         frame_left  = frame_left - 32'd1;
         done = (frame_left == 32'h0);
         if (done) frame_active = 1'b0;
         due(pbyte ^ kb, 1'b0, done, 1'b0);
         payload_words++;
      end
   endfunction

   task automatic send_word(input logic kind, input logic [3:0] op, input logic [31:0] len,
                            input logic [31:0] key, input logic [7:0] pbyte);
      int gap;
      gap = (!quiet && $urandom_range(0, 99) < 20) ? $urandom_range(1, 2) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_type           <= kind;
      req_opcode         <= op;
      req_payload_length <= len;
      req_mask_key       <= key;
      req_payload_byte   <= pbyte;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      encode_word(kind, op, len, key, pbyte);
      words_sent++;
   endtask

   task automatic send_frame(input logic [3:0] op, input logic [31:0] len, input int count);
      send_word(REQ_START, op, len, $urandom, 8'($urandom));
      repeat (count) send_word(REQ_PAYLOAD, 4'($urandom), $urandom, $urandom, 8'($urandom));
   endtask

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // output checker and receiver stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (wire_bytes_due.size() == 0) begin
            $display("%0t: unexpected word, expected none actual %0h hdr %0b last %0b err %0b",
                     $time, rsp_out_byte, rsp_is_header, rsp_frame_last, rsp_seq_error);
            mismatches++;
         end else begin
            check_field("out_byte", wire_bytes_due[0].data, rsp_out_byte);
            check_field("is_header", {7'h0, wire_bytes_due[0].hdr}, {7'h0, rsp_is_header});
            check_field("frame_last", {7'h0, wire_bytes_due[0].last}, {7'h0, rsp_frame_last});
            check_field("seq_error", {7'h0, wire_bytes_due[0].err}, {7'h0, rsp_seq_error});
            void'(wire_bytes_due.pop_front());
            bytes_checked++;
         end
      end
      if (pressure_req != pressure_seen) begin
         pressure_seen = pressure_req;
         hold_left = pressure_len;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(0, 99) < 20);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                  wire_bytes_due.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic test_orphan_payload();
      send_word(REQ_PAYLOAD, 4'h0, 32'h0, 32'h0, 8'h00);
      send_word(REQ_PAYLOAD, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
   endtask

   task automatic test_length_forms();
      send_word(REQ_START, 4'h1, 32'h0, 32'hA5C3_0F81, 8'h00);
      send_word(REQ_START, 4'h2, 32'd3, 32'hFFFF_FFFF, 8'h00);
      send_word(REQ_PAYLOAD, 4'h0, 32'h0, 32'h0, 8'h00);
      send_word(REQ_PAYLOAD, 4'h0, 32'h0, 32'h0, 8'hFF);
      send_word(REQ_PAYLOAD, 4'h0, 32'h0, 32'h0, 8'h5A);
      send_word(REQ_PAYLOAD, 4'h0, 32'h0, 32'h0, 8'h33);
      send_word(REQ_START, 4'h8, 32'd1, 32'h0000_0000, 8'h00);
      send_word(REQ_PAYLOAD, 4'h0, 32'h0, 32'h0, 8'hC7);
      send_word(REQ_START, 4'h0, LEN7_LIMIT, 32'h1234_5678, 8'h00);
      send_word(REQ_PAYLOAD, 4'h0, 32'h0, 32'h0, 8'h01);
      send_word(REQ_PAYLOAD, 4'h0, 32'h0, 32'h0, 8'h80);
      // new start abandons the open frame
      send_word(REQ_START, 4'hF, 32'h0000_007E, 32'hDEAD_BEEF, 8'h00);
      send_word(REQ_PAYLOAD, 4'h0, 32'h0, 32'h0, 8'hAA);
      send_word(REQ_START, 4'h9, LEN16_LIMIT, 32'h8000_0001, 8'h00);
      send_word(REQ_START, 4'hA, 32'h0001_0000, 32'h7FFF_FFFE, 8'h00);
      send_word(REQ_PAYLOAD, 4'h0, 32'h0, 32'h0, 8'h55);
      send_word(REQ_START, 4'h7, 32'hFFFF_FFFF, 32'h0102_0304, 8'h00);
      send_word(REQ_START, 4'h3, 32'h0, 32'h0, 8'h00);
      send_word(REQ_PAYLOAD, 4'h0, 32'h0, 32'h0, 8'hFF);
   endtask

   task automatic test_output_hold();
      pressure_len = 300;
      pressure_req++;
      quiet = 1'b1;
      send_frame(4'($urandom), 32'd40, 40);
      quiet = 1'b0;
   endtask

   task automatic test_random_frames(input int budget);
      int pick;
      int len;
      while (words_sent < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            send_frame(4'($urandom), len, len);
         end else if (pick < 83) begin
            send_frame(4'($urandom), $urandom, $urandom_range(0, 3));
         end else if (pick < 90) begin
            send_frame(4'($urandom), $urandom_range(32'h7E, 32'hFFFF), $urandom_range(0, 3));
         end else begin
            len = $urandom_range(1, 8);
            send_frame(4'($urandom), len, len + $urandom_range(1, 3));
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_orphan_payload();
      test_length_forms();
      test_output_hold();
      test_random_frames(words_sent + 120);
      quiet = 1'b1;
      test_random_frames(words_sent + 60);
      quiet = 1'b0;
      test_random_frames(WORD_BUDGET);
      req_valid <= 1'b0;
      while (wire_bytes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d frame starts, %0d payload words, %0d words outside a frame",
               frames_started, payload_words, orphan_words);
      $display("%0d output words checked over all length forms, empty, abandoned frames",
               bytes_checked);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
